@@ sv/pfsa_pkg.sv @@
// Shared types and constants of the page frame stack allocator.
package pfsa_pkg;

    localparam int FIELD_W  = 48;
    localparam int COUNT_W  = 13;
    localparam int DROP_W   = 40;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_REGION = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd2;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    localparam logic [FIELD_W-1:0] MIN_ADDR_RESET = 48'h0000_0010_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 13'd8191;
    localparam logic [DROP_W-1:0]  DROP_MAX       = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] status;
    } pfsa_ctl_t;

endpackage

@@ sv/pfsa_if.sv @@
// Request and response channel interfaces of the page frame stack allocator.
interface pfsa_req_if;
    logic                          valid;
    logic                          ready;
    logic [pfsa_pkg::OP_W-1:0]     op;
    logic [pfsa_pkg::FIELD_W-1:0]  address;
    logic [pfsa_pkg::FIELD_W-1:0]  region_length;
    logic                          region_usable;

    modport source (output valid, output op, output address, output region_length,
                    output region_usable, input ready);
    modport sink (input valid, input op, input address, input region_length,
                  input region_usable, output ready);
endinterface

interface pfsa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [pfsa_pkg::FIELD_W-1:0]    page_address;
    logic [pfsa_pkg::STATUS_W-1:0]   status;
    logic [pfsa_pkg::COUNT_W-1:0]    free_count;
    logic [pfsa_pkg::COUNT_W-1:0]    managed_count;
    logic [pfsa_pkg::COUNT_W-1:0]    used_count;
    logic [pfsa_pkg::DROP_W-1:0]     dropped_count;

    modport source (output valid, output page_address, output status, output free_count,
                    output managed_count, output used_count, output dropped_count,
                    input ready);
    modport sink (input valid, input page_address, input status, input free_count,
                  input managed_count, input used_count, input dropped_count,
                  output ready);
endinterface

@@ sv/pfsa_front.sv @@
// Front end: accepts request items, rounds regions to page numbers and checks frees.
module pfsa_front #(
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 48,
    parameter int PN_W       = 38
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pfsa_pkg::FIELD_W-1:0]  cfg_wdata,
    pfsa_req_if.sink                      req,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output pfsa_pkg::pfsa_ctl_t           cmd_ctl,
    output logic [PN_W-1:0]               cmd_start,
    output logic [PN_W-1:0]               cmd_end
);

    localparam int FW = pfsa_pkg::FIELD_W;
    localparam logic [FW-1:0] AMASK = (ADDR_BITS >= FW) ? {FW{1'b1}} :
        FW'((65'(1) << ADDR_BITS) - 65'(1));
    localparam logic [FW-1:0] MIN_RESET_M = pfsa_pkg::MIN_ADDR_RESET & AMASK;
    localparam logic [PN_W-1:0] MIN_PN_RESET = PN_W'(MIN_RESET_M >> PAGE_SHIFT) +
        PN_W'(|MIN_RESET_M[PAGE_SHIFT-1:0]);
    localparam logic [PN_W-1:0] PN_LIMIT = PN_W'(1) << (ADDR_BITS - PAGE_SHIFT);

    logic [PN_W-1:0]       min_pn_reg;
    logic [FW-1:0]         cfg_m;
    logic                  valid_reg;
    pfsa_pkg::pfsa_ctl_t   ctl_reg;
    pfsa_pkg::pfsa_ctl_t   ctl_next;
    logic [PN_W-1:0]       start_reg;
    logic [PN_W-1:0]       start_next;
    logic [PN_W-1:0]       end_reg;
    logic [PN_W-1:0]       end_next;
    logic [PN_W-1:0]       base_pn;
    logic [PN_W-1:0]       len_pn;
    logic [PN_W-1:0]       start_raw;
    logic [PN_W-1:0]       end_raw;
    logic [PAGE_SHIFT:0]   off_sum;
    logic                  off_nz;
    logic                  take;

    assign req.ready = !valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;
    assign cmd_valid = valid_reg;
    assign cmd_ctl   = ctl_reg;
    assign cmd_start = start_reg;
    assign cmd_end   = end_reg;
    assign cfg_m     = cfg_wdata & AMASK;

    always_comb
    begin
        base_pn   = PN_W'(req.address >> PAGE_SHIFT);
        len_pn    = PN_W'(req.region_length >> PAGE_SHIFT);
        off_nz    = |req.address[PAGE_SHIFT-1:0];
        off_sum   = {1'b0, req.address[PAGE_SHIFT-1:0]} +
                    {1'b0, req.region_length[PAGE_SHIFT-1:0]};
        start_raw = base_pn + PN_W'(off_nz);
        end_raw   = base_pn + len_pn + PN_W'(off_sum[PAGE_SHIFT]);
        ctl_next.op     = req.op;
        ctl_next.status = pfsa_pkg::ST_OK;
        start_next      = base_pn;
        end_next        = '0;
        unique case (req.op)
            pfsa_pkg::OP_REGION:
            begin
                start_next = (start_raw < min_pn_reg) ? min_pn_reg : start_raw;
                if (req.region_usable)
                begin
                    end_next = (end_raw > PN_LIMIT) ? PN_LIMIT : end_raw;
                end
            end
            pfsa_pkg::OP_FREE:
            begin
                priority if (req.address == '0)
                begin
                    ctl_next.status = pfsa_pkg::ST_ZERO;
                end
                else if (off_nz)
                begin
                    ctl_next.status = pfsa_pkg::ST_MISALIGNED;
                end
                else
                begin
                    ctl_next.status = pfsa_pkg::ST_OK;
                end
            end
            pfsa_pkg::OP_CLEAR, pfsa_pkg::OP_ALLOC:
            begin
                ctl_next.status = pfsa_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            min_pn_reg <= MIN_PN_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                min_pn_reg <= PN_W'(cfg_m >> PAGE_SHIFT) + PN_W'(|cfg_m[PAGE_SHIFT-1:0]);
            end
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            else if (cmd_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctl_reg   <= ctl_next;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

endmodule

@@ sv/pfsa_fifo.sv @@
// Two-entry command queue between the front end and the stack engine.
module pfsa_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic         push;
    logic         pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/pfsa_back.sv @@
// Stack engine: holds the free page stack and counters and produces response items.
module pfsa_back #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 48,
    parameter int PN_W       = 38
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  pfsa_pkg::pfsa_ctl_t  cmd_ctl,
    input  logic [PN_W-1:0]      cmd_start,
    input  logic [PN_W-1:0]      cmd_end,
    pfsa_rsp_if.source           rsp
);

    localparam int FRW = ADDR_BITS - PAGE_SHIFT;
    localparam int TW  = $clog2(MAX_PAGES + 1);
    localparam int AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW  = pfsa_pkg::COUNT_W;
    localparam int DW  = pfsa_pkg::DROP_W;
    localparam int UW  = (TW > CW) ? TW : CW;
    localparam int SW  = ((PN_W > DW) ? PN_W : DW) + 1;
    localparam logic [TW-1:0] TOP_FULL = TW'(MAX_PAGES);

    typedef enum logic [1:0] {S_IDLE, S_REGION, S_SAT, S_EMIT} state_t;

    logic [FRW-1:0] stack_mem [MAX_PAGES];

    state_t                        state_reg, state_next;
    logic [TW-1:0]                 top_reg, top_next;
    logic [CW-1:0]                 managed_reg, managed_next;
    logic [DW-1:0]                 dropped_reg, dropped_next;
    logic [PN_W-1:0]               cur_reg, cur_next;
    logic [PN_W-1:0]               end_reg, end_next;
    logic [PN_W-1:0]               drop_reg, drop_next;
    logic [pfsa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          alloc_ok_reg, alloc_ok_next;
    logic [FRW-1:0]                rd_reg;
    logic                          out_valid_reg;
    logic [pfsa_pkg::FIELD_W-1:0]  out_page_reg;
    logic [pfsa_pkg::STATUS_W-1:0] out_status_reg;
    logic [CW-1:0]                 out_free_reg;
    logic [CW-1:0]                 out_managed_reg;
    logic [CW-1:0]                 out_used_reg;
    logic [DW-1:0]                 out_dropped_reg;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [FRW-1:0]                mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic                          emit;
    logic                          clear_go;
    logic [SW-1:0]                 drop_sum;
    logic [UW-1:0]                 managed_x;
    logic [UW-1:0]                 top_x;
    logic [pfsa_pkg::FIELD_W-1:0]  page_value;

    assign cmd_ready         = (state_reg == S_IDLE);
    assign clear_go          = cmd_valid && cmd_ready && (cmd_ctl.op == pfsa_pkg::OP_CLEAR);
    assign emit              = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);
    assign drop_sum          = SW'(dropped_reg) + SW'(drop_reg);
    assign managed_x         = UW'(managed_reg);
    assign top_x             = UW'(top_reg);
    assign page_value        = alloc_ok_reg ?
        pfsa_pkg::FIELD_W'({rd_reg, {PAGE_SHIFT{1'b0}}}) : '0;

    assign rsp.valid         = out_valid_reg;
    assign rsp.page_address  = out_page_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.free_count    = out_free_reg;
    assign rsp.managed_count = out_managed_reg;
    assign rsp.used_count    = out_used_reg;
    assign rsp.dropped_count = out_dropped_reg;

    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        managed_next  = managed_reg;
        dropped_next  = dropped_reg;
        cur_next      = cur_reg;
        end_next      = end_reg;
        drop_next     = drop_reg;
        status_next   = status_reg;
        alloc_ok_next = alloc_ok_reg;
        mem_we        = 1'b0;
        mem_waddr     = top_reg[AW-1:0];
        mem_wdata     = cur_reg[FRW-1:0];
        mem_re        = 1'b0;
        mem_raddr     = AW'(top_reg - TW'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    status_next = pfsa_pkg::ST_OK;
                    state_next  = S_EMIT;
                    unique case (cmd_ctl.op)
                        pfsa_pkg::OP_CLEAR:
                        begin
                            top_next     = '0;
                            managed_next = '0;
                            dropped_next = '0;
                        end
                        pfsa_pkg::OP_REGION:
                        begin
                            cur_next   = cmd_start;
                            end_next   = cmd_end;
                            state_next = S_REGION;
                        end
                        pfsa_pkg::OP_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                status_next = pfsa_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                top_next      = top_reg - TW'(1);
                                mem_re        = 1'b1;
                                alloc_ok_next = 1'b1;
                            end
                        end
                        pfsa_pkg::OP_FREE:
                        begin
                            priority if (cmd_ctl.status != pfsa_pkg::ST_OK)
                            begin
                                status_next = cmd_ctl.status;
                            end
                            else if (top_reg == TOP_FULL)
                            begin
                                status_next = pfsa_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = cmd_start[FRW-1:0];
                                top_next  = top_reg + TW'(1);
                            end
                        end
                    endcase
                end
            end
            S_REGION:
            begin
                if (cur_reg < end_reg)
                begin
                    if (top_reg != TOP_FULL)
                    begin
                        mem_we       = 1'b1;
                        top_next     = top_reg + TW'(1);
                        cur_next     = cur_reg + PN_W'(1);
                        managed_next = (managed_reg == pfsa_pkg::COUNT_MAX) ?
                                       managed_reg : managed_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next   = end_reg - cur_reg;
                        status_next = pfsa_pkg::ST_FULL;
                        state_next  = S_SAT;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SAT:
            begin
                dropped_next = (drop_sum > SW'(pfsa_pkg::DROP_MAX)) ?
                               pfsa_pkg::DROP_MAX : drop_sum[DW-1:0];
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    alloc_ok_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            managed_reg   <= '0;
            dropped_reg   <= '0;
            alloc_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            managed_reg  <= managed_next;
            dropped_reg  <= dropped_next;
            alloc_ok_reg <= alloc_ok_next;
            cur_reg      <= cur_next;
            end_reg      <= end_next;
            drop_reg     <= drop_next;
            status_reg   <= status_next;
            if (emit)
            begin
                out_valid_reg   <= 1'b1;
                out_page_reg    <= page_value;
                out_status_reg  <= status_reg;
                out_free_reg    <= CW'(top_reg);
                out_managed_reg <= managed_reg;
                out_used_reg    <= (managed_x > top_x) ? CW'(managed_x - top_x) : '0;
                out_dropped_reg <= dropped_reg;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= stack_mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_top_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TOP_FULL)
        else $error("stack pointer beyond capacity");

    a_alloc_flag_emit: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_ok_reg |-> (state_reg == S_EMIT))
        else $error("allocate result flag held outside emit");

    a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !alloc_ok_reg) |=> (rsp.page_address == '0))
        else $error("page address set on an item that is not an allocate");

    a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (dropped_reg < $past(dropped_reg)) |-> $past(clear_go))
        else $error("dropped count fell without a clear");
`endif

endmodule

@@ sv/page_frame_stack_allocator.sv @@
// Top level of the page frame stack allocator: front end, command queue and stack engine.
//
// Channel  Role      Payload
// req      sink      op, address, region_length, region_usable
// rsp      source    page_address, status, free_count, managed_count, used_count,
//                    dropped_count
// cfg      write     cfg_we, cfg_wdata (min_usable_address)
//
// Clear, allocate and free items pass the front-end register, the queue write, the engine's
// idle and emit states and the response register on the way to a response.
// An add-region item also passes the engine's region state, which pushes one page per cycle
// into the stack memory, and its saturate state when pages are dropped.
// Reset clears the stack pointer and counters at once; the stack memory needs no clear.
// The front end keeps accepting while the engine or the response side stalls, until its
// output register and the two-entry queue are full.
module page_frame_stack_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pfsa_pkg::FIELD_W-1:0]  cfg_wdata,
    pfsa_req_if.sink                      req,
    pfsa_rsp_if.source                    rsp
);

    localparam int PN_W = ((ADDR_BITS + 1 > 50) ? ADDR_BITS + 1 : 50) - PAGE_SHIFT;
    localparam int CTL_W = $bits(pfsa_pkg::pfsa_ctl_t);
    localparam int QW = CTL_W + 2 * PN_W;

    logic                  f_valid;
    logic                  f_ready;
    pfsa_pkg::pfsa_ctl_t   f_ctl;
    logic [PN_W-1:0]       f_start;
    logic [PN_W-1:0]       f_end;
    logic                  b_valid;
    logic                  b_ready;
    logic [QW-1:0]         b_data;
    pfsa_pkg::pfsa_ctl_t   b_ctl;
    logic [PN_W-1:0]       b_start;
    logic [PN_W-1:0]       b_end;

    assign b_ctl   = b_data[QW-1:2*PN_W];
    assign b_start = b_data[2*PN_W-1:PN_W];
    assign b_end   = b_data[PN_W-1:0];

    pfsa_front #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .ADDR_BITS  (ADDR_BITS),
        .PN_W       (PN_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_ctl   (f_ctl),
        .cmd_start (f_start),
        .cmd_end   (f_end)
    );

    pfsa_fifo #(
        .W (QW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_ctl, f_start, f_end}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    pfsa_back #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .ADDR_BITS  (ADDR_BITS),
        .PN_W       (PN_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_ctl   (b_ctl),
        .cmd_start (b_start),
        .cmd_end   (b_end),
        .rsp       (rsp)
    );

endmodule

@@ sim/pfsa_checker.sv @@
// Response checker for the page frame stack allocator: predicts each result and compares it.
module pfsa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pfsa_pkg::FIELD_W-1:0]  cfg_wdata,
    pfsa_req_if                           req,
    pfsa_rsp_if                           rsp,
    output int                            outstanding,
    output int                            errors,
    output int                            checked
);

    localparam int FW          = pfsa_pkg::FIELD_W;
    localparam int SW          = pfsa_pkg::STATUS_W;
    localparam int CW          = pfsa_pkg::COUNT_W;
    localparam int DW          = pfsa_pkg::DROP_W;
    localparam int OW          = pfsa_pkg::OP_W;
    localparam int STACK_SLOTS = 4096;
    localparam int PAGE_SHIFT  = 12;
    localparam int FRAME_W     = 36;
    localparam logic [63:0] FRAME_LIMIT = 64'd1 << FRAME_W;

    typedef struct packed {
        logic [FW-1:0] page_address;
        logic [SW-1:0] status;
        logic [CW-1:0] free_count;
        logic [CW-1:0] managed_count;
        logic [CW-1:0] used_count;
        logic [DW-1:0] dropped_count;
    } alloc_result_t;

    logic [FRAME_W-1:0] frame_stack [STACK_SLOTS];
    int                 stack_depth;
    int                 managed_total;
    logic [DW-1:0]      dropped_total;
    logic [FW-1:0]      min_address;
    alloc_result_t      expected_results [$];
    int                 mismatch_total;
    int                 result_total;

    function automatic logic [63:0] page_ceil(logic [FW-1:0] value);
        return ({16'd0, value} >> PAGE_SHIFT) +
               ((value[PAGE_SHIFT-1:0] != 0) ? 64'd1 : 64'd0);
    endfunction

    // Pushes the whole pages of a region, ascending, and returns its status.
    function automatic logic [SW-1:0] load_region(logic [FW-1:0] base,
                                                  logic [FW-1:0] len);
        logic [63:0] first_pn;
        logic [63:0] last_pn;
        logic [63:0] min_pn;
        logic [63:0] pages;
        logic [63:0] room;
        logic [63:0] taken;
        logic [63:0] spill;
        logic [63:0] k;
        first_pn = page_ceil(base);
        last_pn  = ({16'd0, base} >> PAGE_SHIFT) + ({16'd0, len} >> PAGE_SHIFT)
                 + (({52'd0, base[PAGE_SHIFT-1:0]} + {52'd0, len[PAGE_SHIFT-1:0]})
                    >> PAGE_SHIFT);
        min_pn   = page_ceil(min_address);
        if (last_pn > FRAME_LIMIT)
            last_pn = FRAME_LIMIT;
        if (first_pn < min_pn)
            first_pn = min_pn;
        if (last_pn <= first_pn)
            return pfsa_pkg::ST_OK;
        pages = last_pn - first_pn;
        room  = 64'(STACK_SLOTS - stack_depth);
        taken = (pages < room) ? pages : room;
        for (k = 64'd0; k < taken; k++)
        begin
            frame_stack[stack_depth] = first_pn[FRAME_W-1:0] + k[FRAME_W-1:0];
            stack_depth++;
        end
        managed_total += int'(taken);
        if (managed_total > int'(pfsa_pkg::COUNT_MAX))
            managed_total = int'(pfsa_pkg::COUNT_MAX);
        spill = pages - taken;
        if (spill > {24'd0, pfsa_pkg::DROP_MAX - dropped_total})
            dropped_total = pfsa_pkg::DROP_MAX;
        else
            dropped_total = dropped_total + spill[DW-1:0];
        return (spill != 0) ? pfsa_pkg::ST_FULL : pfsa_pkg::ST_OK;
    endfunction

    function automatic alloc_result_t serve_request(logic [OW-1:0] op,
                                                    logic [FW-1:0] address,
                                                    logic [FW-1:0] len,
                                                    logic usable);
        alloc_result_t res;
        int            used;
        res = '0;
        unique case (op)
            pfsa_pkg::OP_CLEAR:
            begin
                stack_depth   = 0;
                managed_total = 0;
                dropped_total = '0;
            end
            pfsa_pkg::OP_REGION:
            begin
                if (usable)
                    res.status = load_region(address, len);
            end
            pfsa_pkg::OP_ALLOC:
            begin
                if (stack_depth == 0)
                    res.status = pfsa_pkg::ST_EMPTY;
                else
                begin
                    stack_depth--;
                    res.page_address = {frame_stack[stack_depth], 12'd0};
                end
            end
            pfsa_pkg::OP_FREE:
            begin
                if (address == 0)
                    res.status = pfsa_pkg::ST_ZERO;
                else if (address[PAGE_SHIFT-1:0] != 0)
                    res.status = pfsa_pkg::ST_MISALIGNED;
                else if (stack_depth >= STACK_SLOTS)
                    res.status = pfsa_pkg::ST_FULL;
                else
                begin
                    frame_stack[stack_depth] = address[FW-1:PAGE_SHIFT];
                    stack_depth++;
                end
            end
        endcase
        used = (managed_total > stack_depth) ? (managed_total - stack_depth) : 0;
        res.free_count    = stack_depth[CW-1:0];
        res.managed_count = managed_total[CW-1:0];
        res.used_count    = used[CW-1:0];
        res.dropped_count = dropped_total;
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_total++;
        end
    endtask

    task automatic compare_result();
        alloc_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with no item waiting: page_address %0h status %0d",
                   rsp.page_address, rsp.status);
            mismatch_total++;
        end
        else
        begin
            want = expected_results.pop_front();
            result_total++;
            check_field("page_address", want.page_address, rsp.page_address);
            check_field("status", want.status, rsp.status);
            check_field("free_count", want.free_count, rsp.free_count);
            check_field("managed_count", want.managed_count, rsp.managed_count);
            check_field("used_count", want.used_count, rsp.used_count);
            check_field("dropped_count", want.dropped_count, rsp.dropped_count);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_depth    = 0;
            managed_total  = 0;
            dropped_total  = '0;
            min_address    = pfsa_pkg::MIN_ADDR_RESET;
            mismatch_total = 0;
            result_total   = 0;
            expected_results.delete();
            outstanding <= 0;
            errors      <= 0;
            checked     <= 0;
        end
        else
        begin
            if (cfg_we)
                min_address = cfg_wdata;
            if (req.valid && req.ready)
                expected_results.push_back(serve_request(req.op, req.address,
                                                         req.region_length,
                                                         req.region_usable));
            if (rsp.valid && rsp.ready)
                compare_result();
            outstanding <= expected_results.size();
            errors      <= mismatch_total;
            checked     <= result_total;
        end
    end

endmodule

@@ sim/testbench.sv @@
// Testbench top for the page frame stack allocator: clock, reset, stimulus and verdict.
module testbench;

    localparam int FW          = pfsa_pkg::FIELD_W;
    localparam int OW          = pfsa_pkg::OP_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [FW-1:0] ADDR_ALL_ONES = '1;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [FW-1:0] cfg_wdata;
    logic [FW-1:0] min_now;
    int            tx_idle_pct;
    int            rx_idle_pct;
    bit            hold_go;
    bit            hold_done;
    int            hold_left;
    int            cycles;
    int            items_sent;
    int            outstanding;
    int            errors;
    int            checked;

    pfsa_req_if req_ch ();
    pfsa_rsp_if rsp_ch ();

    page_frame_stack_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    pfsa_checker alloc_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .outstanding (outstanding),
        .errors      (errors),
        .checked     (checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, outstanding);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(logic [OW-1:0] op, logic [FW-1:0] address,
                             logic [FW-1:0] len, logic usable);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.address       <= address;
        req_ch.region_length <= len;
        req_ch.region_usable <= usable;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_min_address(logic [FW-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        min_now = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Regions mostly start near the minimum address and span a few pages.
    task automatic send_random_item();
        int            pick;
        logic [OW-1:0] op;
        logic [FW-1:0] address;
        logic [FW-1:0] len;
        logic          usable;
        pick    = $urandom_range(99);
        address = FW'({$urandom, $urandom});
        len     = FW'({$urandom, $urandom});
        usable  = ($urandom_range(9) != 0);
        if (pick < 3)
            op = pfsa_pkg::OP_CLEAR;
        else if (pick < 25)
        begin
            op   = pfsa_pkg::OP_REGION;
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                address = min_now + FW'($urandom_range(0, 64 << 12))
                        - FW'($urandom_range(0, 8 << 12));
                len     = FW'($urandom_range(0, 12 << 12));
            end
            else if (pick < 88)
            begin
                address = FW'($urandom_range(0, 32'h0080_0000));
                len     = FW'($urandom_range(0, 12 << 12));
            end
            else if (pick < 95)
                len = FW'($urandom_range(0, 12 << 12));
        end
        else if (pick < 70)
            op = pfsa_pkg::OP_ALLOC;
        else
        begin
            op   = pfsa_pkg::OP_FREE;
            pick = $urandom_range(99);
            if (pick < 10)
                address = '0;
            else if (pick < 55)
                address[11:0] = '0;
            else if (pick < 85)
                address = FW'({$urandom_range(0, 2047), 12'd0});
        end
        send_item(op, address, len, usable);
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        min_now              = pfsa_pkg::MIN_ADDR_RESET;
        req_ch.valid         = 1'b0;
        req_ch.op            = pfsa_pkg::OP_CLEAR;
        req_ch.address       = '0;
        req_ch.region_length = '0;
        req_ch.region_usable = 1'b0;
        rsp_ch.ready         = 1'b0;
        tx_idle_pct          = 13;
        rx_idle_pct          = 68;
        hold_go              = 1'b0;
        hold_done            = 1'b0;
        hold_left            = 0;
        cycles               = 0;
        items_sent           = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under the reset value of the minimum address.
        send_item(pfsa_pkg::OP_ALLOC, '0, '0, 1'b0);
        send_item(pfsa_pkg::OP_FREE, '0, '0, 1'b0);
        send_item(pfsa_pkg::OP_FREE, 48'h0000_0000_1234, '0, 1'b0);
        send_item(pfsa_pkg::OP_FREE, 48'hFFFF_FFFF_F000, '0, 1'b0);
        send_item(pfsa_pkg::OP_ALLOC, '0, '0, 1'b0);
        send_item(pfsa_pkg::OP_REGION, 48'h0000_0020_0000, 48'h0000_0001_0000, 1'b0);
        send_item(pfsa_pkg::OP_REGION, '0, 48'h0000_0010_0000, 1'b1);
        send_item(pfsa_pkg::OP_REGION, 48'h0000_000F_F800, 48'h0000_0000_3000, 1'b1);
        send_item(pfsa_pkg::OP_REGION, 48'h0000_0020_0001, 48'h0000_0000_0FFE, 1'b1);
        send_item(pfsa_pkg::OP_REGION, 48'h0000_0040_0000, '0, 1'b1);
        send_item(pfsa_pkg::OP_REGION, 48'hFFFF_FFFF_E000, ADDR_ALL_ONES, 1'b1);
        send_item(pfsa_pkg::OP_REGION, ADDR_ALL_ONES, ADDR_ALL_ONES, 1'b1);
        send_item(pfsa_pkg::OP_ALLOC, '0, '0, 1'b0);
        send_item(pfsa_pkg::OP_FREE, 48'h0000_0030_0000, '0, 1'b0);
        send_item(pfsa_pkg::OP_FREE, 48'h0000_0000_1000, '0, 1'b0);
        repeat (5) send_item(pfsa_pkg::OP_ALLOC, '0, '0, 1'b0);
        send_item(pfsa_pkg::OP_CLEAR, ADDR_ALL_ONES, ADDR_ALL_ONES, 1'b1);
        send_item(pfsa_pkg::OP_FREE, 48'h0000_0050_0000, '0, 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_min_address('0);
                1: write_min_address(FW'($urandom_range(1, 32'h003F_FFFF)));
                2: write_min_address(ADDR_ALL_ONES);
                default: write_min_address(FW'({$urandom, $urandom}));
            endcase
            if (phase == 0)
            begin
                tx_idle_pct = 13;
                rx_idle_pct = 68;
            end
            else if (phase < 3)
            begin
                tx_idle_pct = 68;
                rx_idle_pct = 13;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_go     = 1'b1;
            end
            repeat ((phase == 2) ? 60 : 410) send_random_item();
        end

        // Fill the stack, saturate the dropped count, free some room and refill it.
        write_min_address(pfsa_pkg::MIN_ADDR_RESET);
        send_item(pfsa_pkg::OP_CLEAR, '0, '0, 1'b0);
        repeat (18) send_item(pfsa_pkg::OP_REGION, '0, ADDR_ALL_ONES, 1'b1);
        send_item(pfsa_pkg::OP_FREE, 48'h0000_0000_5000, '0, 1'b0);
        repeat (6) send_item(pfsa_pkg::OP_ALLOC, '0, '0, 1'b0);
        send_item(pfsa_pkg::OP_REGION, '0, ADDR_ALL_ONES, 1'b1);
        send_item(pfsa_pkg::OP_ALLOC, '0, '0, 1'b0);
        send_item(pfsa_pkg::OP_CLEAR, '0, '0, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Sent %0d items: directed corners, four minimum-address settings and",
                 items_sent);
        $display("three traffic mixes with a long output stall; %0d results compared.",
                 checked);
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
